// ===== src/vrrq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vrrq_pkg
// shared widths, codes and types for the variable record ring queue
// ----------------------------------------------------------------------------
package vrrq_pkg;

  localparam int RING_BYTES = 1024;
  localparam int TAG_BYTES  = 4;

  // offsets, lengths and tags share one width
  localparam int OFS_W  = 11;
  localparam int ADDR_W = $clog2(RING_BYTES);
  // room for offset + tag + length without wrap-around
  localparam int CALC_W = OFS_W + 2;

  localparam logic [1:0] REG_RING_SIZE_ADDR = 2'd0;
  localparam logic [OFS_W-1:0] RING_SIZE_RESET = OFS_W'(RING_BYTES);

  typedef enum logic {
    ACT_ADD = 1'b0,
    ACT_DEL = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // tag memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [OFS_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } tag_req_t;

endpackage

`default_nettype wire

// ===== src/vrrq_tag_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vrrq_tag_ram
// length tag store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vrrq_tag_ram
  import vrrq_pkg::*;
(
  input  wire logic             clk,
  input  wire tag_req_t         req,
  output logic      [OFS_W-1:0] rdata
);

  logic [OFS_W-1:0] mem [RING_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== src/variable_record_ring_queue_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// variable_record_ring_queue_core
// ring of variable-length records, each led by a length tag
// ----------------------------------------------------------------------------
// Each input transaction is an add (reserve tag plus payload at the head,
// wrapping to offset 0 when the record would pass the ring end) or a delete
// (read the tag at the tail and release that record). Every transaction
// returns exactly one result: status, payload offset, length and the head and
// tail offsets after the operation. Only offsets and tags are kept; the tags
// live in a 1024 x 11 synchronous RAM. An add without wrap, a full add, an
// empty delete and a delete without wrap pass through accept and execute;
// an add that wraps and leaves a tag copy at the old head also runs the copy
// state, and a delete that wraps runs a read state, since the tag at offset
// 0 needs a second read through the single RAM read port. A new transaction
// is taken while the previous result still waits on the output; one extra
// result is buffered internally. Tags are not cleared after reset: there is
// no clearing pass, and the block is ready once reset is released. ring_size
// (APB byte address 0) must only be written while the block is idle.
// ----------------------------------------------------------------------------
module variable_record_ring_queue_core
  import vrrq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [10:0] record_length, rest zero
  input  wire logic        s_axis_tuser,  // [0] action

  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // [10:0] payload_offset,
                                          // [21:11] length_out,
                                          // [32:22] head_now,
                                          // [43:33] tail_now, rest zero
  output logic       [1:0] m_axis_tuser,  // [1:0] status

  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic  [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADD2,
    ST_DEL0
  } state_t;

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] tail;
    logic [OFS_W-1:0] head;
    logic [OFS_W-1:0] len;
    logic [OFS_W-1:0] pay;
  } result_t;

  // control and ring state
  state_t           state, state_next;
  logic [OFS_W-1:0] ring_size;
  logic [OFS_W-1:0] head_offset, head_offset_next;
  logic [OFS_W-1:0] tail_offset, tail_offset_next;

  // latched request
  action_t          act;
  logic [OFS_W-1:0] len;
  logic [OFS_W-1:0] copy_addr;

  // result path: output register plus one spare
  result_t          out_res;
  result_t          spare_res;
  logic             spare_valid;
  result_t          fin_res;
  logic             fin;
  logic             out_free;

  // tag memory
  tag_req_t         tag_req;
  logic [OFS_W-1:0] tag_rdata;

  // arithmetic at a width that cannot overflow
  logic [OFS_W-1:0]  size_eff;
  logic [CALC_W-1:0] size_w, head_w, tail_w, len_w, tag_w;
  logic [CALC_W-1:0] rec_w, hnew_w, tail_tag_w, tail_end_w, head_tag_w;
  logic [CALC_W-1:0] zero_end_w;
  logic              cfg_wr;

  vrrq_tag_ram u_tag_ram (
    .clk   (clk),
    .req   (tag_req),
    .rdata (tag_rdata)
  );

  // ring_size above the store saturates at the store size
  assign size_eff   = (ring_size > OFS_W'(RING_BYTES)) ? OFS_W'(RING_BYTES) : ring_size;
  assign size_w     = CALC_W'(size_eff);
  assign head_w     = CALC_W'(head_offset);
  assign tail_w     = CALC_W'(tail_offset);
  assign len_w      = CALC_W'(len);
  assign tag_w      = CALC_W'(tag_rdata);
  assign rec_w      = CALC_W'(TAG_BYTES) + len_w;
  assign hnew_w     = head_w + rec_w;
  assign head_tag_w = head_w + CALC_W'(TAG_BYTES);
  assign tail_tag_w = tail_w + CALC_W'(TAG_BYTES);
  assign tail_end_w = tail_tag_w + tag_w;
  // end of a record that starts at offset 0
  assign zero_end_w = CALC_W'(TAG_BYTES) + tag_w;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // one result in flight at most beyond the output register
  assign s_axis_tready = (state == ST_IDLE) && !spare_valid;

  assign m_axis_tdata = {4'b0, out_res.tail, out_res.head, out_res.len, out_res.pay};
  assign m_axis_tuser = out_res.status;

  // apb: zero wait states, one register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_RING_SIZE_ADDR);
  assign prdata = (paddr == REG_RING_SIZE_ADDR) ? {{(32-OFS_W){1'b0}}, ring_size} : 32'd0;

  always_comb begin
    state_next       = state;
    head_offset_next = head_offset;
    tail_offset_next = tail_offset;
    fin              = 1'b0;
    fin_res          = '{status: STATUS_DONE, tail: '0, head: '0, len: '0, pay: '0};
    tag_req.we       = 1'b0;
    tag_req.waddr    = head_offset[ADDR_W-1:0];
    tag_req.wdata    = len;
    // idle: fetch the tail tag ahead of a possible delete; else the tag at 0
    tag_req.raddr    = (state == ST_IDLE) ? tail_offset[ADDR_W-1:0] : '0;

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_IDLE;
        fin        = 1'b1;
        if (act == ACT_ADD) begin
          if (head_offset >= tail_offset) begin
            if (hnew_w > size_w) begin
              if (rec_w >= tail_w) begin
                fin_res.status = STATUS_FULL;
              end else begin
                // wrap to the ring start, tag copy at old head if it fits
                tag_req.we       = 1'b1;
                tag_req.waddr    = '0;
                fin_res.pay      = OFS_W'(TAG_BYTES);
                fin_res.len      = len;
                head_offset_next = rec_w[OFS_W-1:0];
                if (head_tag_w <= size_w) begin
                  state_next = ST_ADD2;
                end
              end
            end else begin
              tag_req.we       = (head_offset < OFS_W'(RING_BYTES));
              fin_res.pay      = head_tag_w[OFS_W-1:0];
              fin_res.len      = len;
              head_offset_next = hnew_w[OFS_W-1:0];
            end
          end else if (hnew_w >= tail_w) begin
            fin_res.status = STATUS_FULL;
          end else begin
            tag_req.we       = (head_offset < OFS_W'(RING_BYTES));
            fin_res.pay      = head_tag_w[OFS_W-1:0];
            fin_res.len      = len;
            head_offset_next = hnew_w[OFS_W-1:0];
          end
        end else begin
          if (head_offset == tail_offset) begin
            fin_res.status = STATUS_EMPTY;
          end else if ((tail_tag_w <= size_w) && (tail_end_w <= size_w)) begin
            fin_res.pay      = tail_tag_w[OFS_W-1:0];
            fin_res.len      = tag_rdata;
            tail_offset_next = tail_end_w[OFS_W-1:0];
          end else begin
            // record sits at the ring start: read the tag at offset 0
            fin        = 1'b0;
            state_next = ST_DEL0;
          end
        end
      end

      ST_ADD2: begin
        tag_req.we    = 1'b1;
        tag_req.waddr = copy_addr[ADDR_W-1:0];
        state_next    = ST_IDLE;
      end

      ST_DEL0: begin
        fin              = 1'b1;
        fin_res.pay      = OFS_W'(TAG_BYTES);
        fin_res.len      = tag_rdata;
        tail_offset_next = zero_end_w[OFS_W-1:0];
        state_next       = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    fin_res.head = head_offset_next;
    fin_res.tail = tail_offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ring_size     <= RING_SIZE_RESET;
      head_offset   <= '0;
      tail_offset   <= '0;
      spare_valid   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state       <= state_next;
      head_offset <= head_offset_next;
      tail_offset <= tail_offset_next;

      if (cfg_wr) begin
        ring_size <= pwdata[OFS_W-1:0];
      end

      // result delivery: straight to the output, else park in the spare
      if (fin) begin
        if (out_free) begin
          out_res       <= fin_res;
          m_axis_tvalid <= 1'b1;
        end else begin
          spare_res   <= fin_res;
          spare_valid <= 1'b1;
        end
      end else if (spare_valid && out_free) begin
        out_res       <= spare_res;
        spare_valid   <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // request fields and the old head for a wrap tag copy
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act <= action_t'(s_axis_tuser);
      len <= s_axis_tdata[OFS_W-1:0];
    end
    if (state == ST_EXEC) begin
      copy_addr <= head_offset;
    end
  end

  // a parked result always has a valid result ahead of it
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> m_axis_tvalid)
    else $error("spare result held while output register is empty");

  // an accepted transaction goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_EXEC))
    else $error("accepted transaction did not enter execution");

  // the tag store is never written between transactions
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !tag_req.we)
    else $error("tag write while idle");

  // ring offsets only move while a transaction is executing
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> ($stable(head_offset) && $stable(tail_offset)))
    else $error("head or tail changed while idle");

  // the wrap copy step only follows an add
  a_add2_from_add: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD2) |-> (act == ACT_ADD))
    else $error("tag copy step outside an add");

endmodule

`default_nettype wire
